### hdl/mia_pkg.sv
// Shared widths and types of the mutual information accumulator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mia_pkg;

  // Probabilities are unsigned Q0.16 carried in 17 bits so 1.0 fits.
  localparam int PROB_W   = 17;
  // Result word, signed Q15.16.
  localparam int INFO_W   = 32;
  localparam int OUT_FRAC = 16;
  // Running sum, signed Q31.32.
  localparam int SUM_W    = 64;
  // Operand width of the shared multiplier.
  localparam int MUL_W    = 32;
  // Log mantissa in Q1.30 and the integer part of the log.
  localparam int MANT_W   = 31;
  localparam int EXP_W    = 5;

  typedef logic [PROB_W-1:0]        prob_t;
  typedef logic signed [INFO_W-1:0] info_t;

endpackage

`default_nettype wire

### hdl/mia_in_if.sv
// Input channel of the mutual information accumulator: one term per request.
// Depends on mia_pkg for the probability type.
`default_nettype none

interface mia_in_if import mia_pkg::*; ();

  logic  valid;
  logic  ready;
  prob_t cond_prob;
  prob_t marginal_a;
  prob_t prior_b;
  logic  last_term;

  modport source (output valid, cond_prob, marginal_a, prior_b, last_term, input ready);
  modport sink   (input valid, cond_prob, marginal_a, prior_b, last_term, output ready);

endinterface

`default_nettype wire

### hdl/mia_out_if.sv
// Result channel of the mutual information accumulator: one sum per last request.
// Depends on mia_pkg for the result type.
`default_nettype none

interface mia_out_if import mia_pkg::*; ();

  logic  valid;
  logic  ready;
  info_t info_bits;
  logic  clipped;

  modport source (output valid, info_bits, clipped, input ready);
  modport sink   (input valid, info_bits, clipped, output ready);

endinterface

`default_nettype wire

### hdl/mutual_information_accumulator_top.sv
// Mutual information accumulator, base 2, with one shared multiplier.
// Depends on mia_pkg, mia_in_if and mia_out_if.
//
// Usage: each request on in_ch carries one term p(a|b), p(a), p(b) in
// unsigned Q0.16 and a last mark. Terms whose p(a|b) or p(a) is zero or
// below the skip threshold (written through cfg_wr_en / cfg_wr_data, reset
// value 1) add nothing. On the last request the sum goes out on out_ch as
// signed Q15.16, rounded and saturated, with clipped set on saturation,
// and the sum is cleared.
// A request is taken only in the idle state, so a new term is taken only
// once the previous one has been added to the sum or skipped, and after a
// last term only once its result has been loaded into the output register.
// The time of a computed term is set by the shared 32x32 multiplier, which
// squares the log mantissa once per fraction bit for both logarithms, then
// forms the product of the three factors in three more passes.
// On a last request the sum is rounded in ST_FIN, after the term is added or
// skipped, and saturated into the output register in ST_OUT.
// The result sits in an output register, so new requests are taken while
// the receiver stalls; a second result waits until that register frees.
// Reset (rst_n, synchronous) clears the sum, the threshold to 1 and valid.
`default_nettype none

module mutual_information_accumulator_top import mia_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  prob_t     cfg_wr_data,
  mia_in_if.sink    in_ch,
  mia_out_if.source out_ch
);

  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam int FR_W   = FRAC_BITS + 1;
  localparam int L_W    = FRAC_BITS + EXP_W;
  localparam int RND_W  = SUM_W - FRAC_BITS;
  localparam int PROD_W = 2 * PROB_W;
  localparam int RR_W   = SUM_W - OUT_FRAC;

  localparam logic [SUM_W-1:0] TERM_HALF    = SUM_W'(1) << (FRAC_BITS - 1);
  localparam logic [SUM_W-1:0] OUT_HALF     = SUM_W'(1) << (OUT_FRAC - 1);
  localparam logic [SUM_W-1:0] OUT_HALF_NEG = OUT_HALF + SUM_W'(1);
  localparam logic [SUM_W-1:0] SUM_MAX      = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN      = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [RR_W-1:0]  NEG_LIM      = RR_W'(1) << (INFO_W - 1);
  localparam logic [RR_W-1:0]  POS_LIM      = NEG_LIM - RR_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG,
    ST_LOG_END,
    ST_MUL_P,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_RND,
    ST_ACC,
    ST_FIN,
    ST_OUT
  } state_t;

  // Index of the top set bit, bit 0 when only that one is set.
  function automatic logic [EXP_W-1:0] top_bit(input prob_t v);
    logic [EXP_W-1:0] idx;
    idx = '0;
    for (int i = 1; i < PROB_W; i++) begin
      if (v[i]) idx = EXP_W'(i);
    end
    return idx;
  endfunction

  // Mantissa in Q1.30 with the top set bit moved to bit 30.
  function automatic logic [MANT_W-1:0] norm_mant(input prob_t v, input logic [EXP_W-1:0] e);
    return MANT_W'(v) << (EXP_W'(MANT_W - 1) - e);
  endfunction

  state_t               state_r, state_nxt;
  prob_t                thr_r, thr_nxt;
  prob_t                pc_r, pc_nxt;
  prob_t                pa_r, pa_nxt;
  prob_t                pb_r, pb_nxt;
  logic                 last_r, last_nxt;
  logic                 sel_r, sel_nxt;
  logic [MANT_W-1:0]    m_r, m_nxt;
  logic [EXP_W-1:0]     e_r, e_nxt;
  logic [FR_W-1:0]      frac_r, frac_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [L_W-1:0]       lc_r, lc_nxt;
  logic [L_W-1:0]       la_r, la_nxt;
  logic [L_W-1:0]       d_r, d_nxt;
  logic                 neg_r, neg_nxt;
  logic [PROD_W-1:0]    p_r, p_nxt;
  logic [SUM_W-1:0]     acc_r, acc_nxt;
  logic [RND_W-1:0]     r_r, r_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic                 sneg_r, sneg_nxt;
  logic [RR_W-1:0]      rr_r, rr_nxt;
  logic                 out_valid_r, out_valid_nxt;
  info_t                info_r, info_nxt;
  logic                 clip_r, clip_nxt;

  logic                 in_acc;
  logic                 skip;
  logic [EXP_W-1:0]     e_pc, e_pa;
  logic [MUL_W-1:0]     mul_a, mul_b;
  logic [2*MUL_W-1:0]   mul_p;
  logic [MANT_W:0]      sq;
  logic                 sq_bit;
  logic [MANT_W-1:0]    m_sq;
  logic [FR_W:0]        fr_inc;
  logic [L_W-1:0]       l_val;
  logic [SUM_W:0]       ext_sum, ext_r, add_res;
  logic [SUM_W-1:0]     ofs;
  logic                 rr_clip;
  logic [INFO_W-1:0]    word;

  // Handshake and skip decision on the incoming term.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign skip        = (in_ch.cond_prob == '0) || (in_ch.marginal_a == '0) ||
                       (in_ch.cond_prob < thr_r) || (in_ch.marginal_a < thr_r);
  assign e_pc        = top_bit(in_ch.cond_prob);
  assign e_pa        = top_bit(pa_r);

  // Shared multiplier: mantissa squaring, then the three product passes.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_LOG: begin
        mul_a = MUL_W'(m_r);
        mul_b = MUL_W'(m_r);
      end
      ST_MUL_P: begin
        mul_a = MUL_W'(pb_r);
        mul_b = MUL_W'(pc_r);
      end
      ST_MUL_LO: begin
        mul_a = MUL_W'(p_r[PROB_W-1:0]);
        mul_b = MUL_W'(d_r);
      end
      ST_MUL_HI: begin
        mul_a = MUL_W'(p_r[PROD_W-1:PROB_W]);
        mul_b = MUL_W'(d_r);
      end
      default: ;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // One fraction bit per squaring; renormalize when the square reaches 2.0.
  assign sq     = mul_p[2*MANT_W-1:MANT_W-1];
  assign sq_bit = sq[MANT_W];
  assign m_sq   = sq_bit ? sq[MANT_W:1] : sq[MANT_W-1:0];

  // Log value with the extra fraction bit used for rounding to nearest.
  assign fr_inc = {1'b0, frac_r} + (FR_W+1)'(1);
  assign l_val  = {e_r, {FRAC_BITS{1'b0}}} + L_W'(fr_inc[FR_W:1]);

  // Saturating add of the signed term into the running sum.
  assign ext_sum = {sum_r[SUM_W-1], sum_r};
  assign ext_r   = (SUM_W+1)'(r_r);
  assign add_res = neg_r ? (ext_sum - ext_r) : (ext_sum + ext_r);

  // Magnitude of the sum plus one half at the output scale.
  assign ofs = sum_r[SUM_W-1] ? (~sum_r + OUT_HALF_NEG) : (sum_r + OUT_HALF);

  // Saturation of the rounded magnitude to the result word.
  assign rr_clip = sneg_r ? (rr_r > NEG_LIM) : (rr_r > POS_LIM);
  always_comb begin
    if (sneg_r) begin
      word = rr_clip ? NEG_LIM[INFO_W-1:0] : (INFO_W'(0) - rr_r[INFO_W-1:0]);
    end else begin
      word = rr_clip ? POS_LIM[INFO_W-1:0] : rr_r[INFO_W-1:0];
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    thr_nxt       = thr_r;
    pc_nxt        = pc_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    last_nxt      = last_r;
    sel_nxt       = sel_r;
    m_nxt         = m_r;
    e_nxt         = e_r;
    frac_nxt      = frac_r;
    cnt_nxt       = cnt_r;
    lc_nxt        = lc_r;
    la_nxt        = la_r;
    d_nxt         = d_r;
    neg_nxt       = neg_r;
    p_nxt         = p_r;
    acc_nxt       = acc_r;
    r_nxt         = r_r;
    sum_nxt       = sum_r;
    sneg_nxt      = sneg_r;
    rr_nxt        = rr_r;
    out_valid_nxt = out_valid_r;
    info_nxt      = info_r;
    clip_nxt      = clip_r;

    if (cfg_wr_en) thr_nxt = cfg_wr_data;
    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pc_nxt   = in_ch.cond_prob;
          pa_nxt   = in_ch.marginal_a;
          pb_nxt   = in_ch.prior_b;
          last_nxt = in_ch.last_term;
          if (skip) begin
            state_nxt = in_ch.last_term ? ST_FIN : ST_IDLE;
          end else begin
            e_nxt     = e_pc;
            m_nxt     = norm_mant(in_ch.cond_prob, e_pc);
            frac_nxt  = '0;
            cnt_nxt   = '0;
            sel_nxt   = 1'b0;
            state_nxt = ST_LOG;
          end
        end
      end
      ST_LOG: begin
        m_nxt    = m_sq;
        frac_nxt = {frac_r[FR_W-2:0], sq_bit};
        cnt_nxt  = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(FRAC_BITS)) state_nxt = ST_LOG_END;
      end
      ST_LOG_END: begin
        if (!sel_r) begin
          // First log done; start on the marginal.
          lc_nxt    = l_val;
          e_nxt     = e_pa;
          m_nxt     = norm_mant(pa_r, e_pa);
          frac_nxt  = '0;
          cnt_nxt   = '0;
          sel_nxt   = 1'b1;
          state_nxt = ST_LOG;
        end else begin
          la_nxt    = l_val;
          state_nxt = ST_MUL_P;
        end
      end
      ST_MUL_P: begin
        p_nxt     = mul_p[PROD_W-1:0];
        neg_nxt   = lc_r < la_r;
        d_nxt     = (lc_r < la_r) ? (la_r - lc_r) : (lc_r - la_r);
        state_nxt = ST_MUL_LO;
      end
      ST_MUL_LO: begin
        acc_nxt   = SUM_W'(mul_p);
        state_nxt = ST_MUL_HI;
      end
      ST_MUL_HI: begin
        acc_nxt   = acc_r + (SUM_W'(mul_p) << PROB_W);
        state_nxt = ST_RND;
      end
      ST_RND: begin
        r_nxt     = RND_W'((acc_r + TERM_HALF) >> FRAC_BITS);
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        if (add_res[SUM_W] != add_res[SUM_W-1]) begin
          sum_nxt = add_res[SUM_W] ? SUM_MIN : SUM_MAX;
        end else begin
          sum_nxt = add_res[SUM_W-1:0];
        end
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        sneg_nxt  = sum_r[SUM_W-1];
        rr_nxt    = ofs[SUM_W-1:OUT_FRAC];
        sum_nxt   = '0;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // Hold here while the previous result is still waiting.
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          info_nxt      = word;
          clip_nxt      = rr_clip;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State, control and datapath registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= PROB_W'(1);
      sum_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      thr_r       <= thr_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pc_r   <= pc_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
    last_r <= last_nxt;
    sel_r  <= sel_nxt;
    m_r    <= m_nxt;
    e_r    <= e_nxt;
    frac_r <= frac_nxt;
    cnt_r  <= cnt_nxt;
    lc_r   <= lc_nxt;
    la_r   <= la_nxt;
    d_r    <= d_nxt;
    neg_r  <= neg_nxt;
    p_r    <= p_nxt;
    acc_r  <= acc_nxt;
    r_r    <= r_nxt;
    sneg_r <= sneg_nxt;
    rr_r   <= rr_nxt;
    info_r <= info_nxt;
    clip_r <= clip_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.info_bits = info_r;
  assign out_ch.clipped   = clip_r;

  // The mantissa stays normalized in [1.0, 2.0) through the squaring loop.
  a_mant_norm: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOG |-> m_r[MANT_W-1])
    else $error("log mantissa lost normalization");

  // The squaring loop never runs past its last fraction bit.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOG |-> cnt_r <= CNT_W'(FRAC_BITS))
    else $error("log iteration count out of range");

  // The sum is cleared once the final value has been captured.
  a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |=> sum_r == '0)
    else $error("running sum not cleared after a last term");

  // A clipped result sits at one of the two bounds of the word.
  a_clip_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && clip_r |->
      (info_r == info_t'(POS_LIM[INFO_W-1:0]) || info_r == info_t'(NEG_LIM[INFO_W-1:0])))
    else $error("clipped result not at a saturation bound");

endmodule

`default_nettype wire
